// ===== rtl/sdp_pkg.sv =====
// ----------------------------------------------------------------------------
// sdp_pkg: shared types and constants for the stick to d-pad pulser
// Request payloads, the squared-sample bundle between the two stages,
// direction codes, register indexes and register reset values.
// ----------------------------------------------------------------------------
package sdp_pkg;

  typedef struct packed {
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic [15:0]        button_bits;
    logic               menu_active;
    logic [31:0]        now_ms;
  } in_t;

  typedef struct packed {
    logic [15:0]        button_out;
    logic signed [15:0] stick_x_out;
    logic signed [15:0] stick_y_out;
  } out_t;

  typedef enum logic [2:0] {
    DIR_NONE  = 3'd0,
    DIR_UP    = 3'd1,
    DIR_DOWN  = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_RIGHT = 3'd4
  } dir_t;

  // Held direction and pulse phase, carried from one request to the next.
  typedef struct packed {
    dir_t        held;
    logic        pulse_high;
    logic [31:0] phase_start;
  } st_t;

  // A sample after the squaring stage.
  typedef struct packed {
    logic               x_pos;
    logic               y_pos;
    logic               ax_gt_ay;
    logic [31:0]        ax_sq;
    logic [31:0]        ay_sq;
    logic [31:0]        eng_sq;
    logic [31:0]        rel_sq;
    logic [15:0]        button_bits;
    logic               menu_active;
    logic [31:0]        now_ms;
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
  } sq_t;

  localparam logic [1:0] CFG_ENGAGE  = 2'd0;
  localparam logic [1:0] CFG_RELEASE = 2'd1;
  localparam logic [1:0] CFG_PRESS   = 2'd2;
  localparam logic [1:0] CFG_GAP     = 2'd3;

  localparam logic [15:0] ENGAGE_RST  = 16'd12000;
  localparam logic [15:0] RELEASE_RST = 16'd8000;
  localparam logic [15:0] PRESS_RST   = 16'd110;
  localparam logic [15:0] GAP_RST     = 16'd50;

  localparam logic [15:0] DPAD_MASK = 16'h000F;

endpackage

// ===== rtl/sdp_decide.sv =====
// ----------------------------------------------------------------------------
// sdp_decide: direction decision and pulse timing
// Compares the squared magnitude with the active threshold, picks the
// dominant axis, advances the pulse phase and builds the result word.
// ----------------------------------------------------------------------------
module sdp_decide (
  input  sdp_pkg::sq_t  smp,
  input  sdp_pkg::st_t  st_cur,
  input  logic [15:0]   press_time,
  input  logic [15:0]   gap_time,
  output sdp_pkg::out_t res,
  output sdp_pkg::st_t  st_nxt
);

  logic [32:0]   mag;
  logic [31:0]   th_sq;
  logic          engaged;
  sdp_pkg::dir_t dir;
  sdp_pkg::st_t  st_chg;
  logic [31:0]   elapsed;
  logic [15:0]   dpad;

  assign mag     = {1'b0, smp.ax_sq} + {1'b0, smp.ay_sq};
  assign th_sq   = (st_cur.held == sdp_pkg::DIR_NONE) ? smp.eng_sq : smp.rel_sq;
  assign engaged = (mag >= {1'b0, th_sq});

  // On an axis tie the vertical axis wins.
  always_comb begin
    if (!engaged) begin
      dir = sdp_pkg::DIR_NONE;
    end else if (smp.ax_gt_ay) begin
      dir = smp.x_pos ? sdp_pkg::DIR_RIGHT : sdp_pkg::DIR_LEFT;
    end else begin
      dir = smp.y_pos ? sdp_pkg::DIR_UP : sdp_pkg::DIR_DOWN;
    end
  end

  // A new direction restarts the pulse as on, timed from this sample.
  always_comb begin
    st_chg = st_cur;
    if (dir != st_cur.held) begin
      st_chg.held        = dir;
      st_chg.pulse_high  = 1'b1;
      st_chg.phase_start = smp.now_ms;
    end
  end

  assign elapsed = smp.now_ms - st_chg.phase_start;

  always_comb begin
    st_nxt = st_cur;
    dpad   = '0;
    if (smp.menu_active) begin
      if (dir == sdp_pkg::DIR_NONE) begin
        st_nxt.held        = sdp_pkg::DIR_NONE;
        st_nxt.pulse_high  = 1'b1;
        st_nxt.phase_start = '0;
      end else begin
        st_nxt = st_chg;
        if (st_chg.pulse_high) begin
          if (elapsed >= {16'd0, press_time}) begin
            st_nxt.pulse_high  = 1'b0;
            st_nxt.phase_start = smp.now_ms;
          end
        end else begin
          if (elapsed >= {16'd0, gap_time}) begin
            st_nxt.pulse_high  = 1'b1;
            st_nxt.phase_start = smp.now_ms;
          end
        end
        if (st_nxt.pulse_high) begin
          case (st_nxt.held)
            sdp_pkg::DIR_UP:    dpad = 16'h0001;
            sdp_pkg::DIR_DOWN:  dpad = 16'h0002;
            sdp_pkg::DIR_LEFT:  dpad = 16'h0004;
            sdp_pkg::DIR_RIGHT: dpad = 16'h0008;
            default:            dpad = '0;
          endcase
        end
      end
    end
  end

  always_comb begin
    if (smp.menu_active) begin
      res.button_out  = (smp.button_bits & ~sdp_pkg::DPAD_MASK) | dpad;
      res.stick_x_out = '0;
      res.stick_y_out = '0;
    end else begin
      res.button_out  = smp.button_bits;
      res.stick_x_out = smp.stick_x;
      res.stick_y_out = smp.stick_y;
    end
  end

endmodule

// ===== rtl/stick_to_dpad_pulser_unit.sv =====
// ----------------------------------------------------------------------------
// stick_to_dpad_pulser_unit: left stick to pulsed d-pad translation
// A request passes in order through the input register, the squaring stage
// register and the result register. Throughput: one request per cycle while
// out_ready is high; the held-direction state is updated as each request
// enters the result register, so the next one sees it at once.
// Reset (synchronous, rst_n low): pipeline empty, no direction held, pulse on,
// phase start zero, registers at 12000, 8000, 110 and 50.
// ----------------------------------------------------------------------------
module stick_to_dpad_pulser_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sdp_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sdp_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_idx,
  input  logic [15:0]   cfg_wdata
);

  logic [15:0] engage_r;
  logic [15:0] release_r;
  logic [15:0] press_r;
  logic [15:0] gap_r;

  logic          a_valid_r;
  sdp_pkg::in_t  a_r;
  logic          b_valid_r;
  sdp_pkg::sq_t  b_r;
  sdp_pkg::sq_t  b_nxt;
  logic          out_valid_r;
  sdp_pkg::out_t out_r;

  sdp_pkg::st_t  st_r;
  sdp_pkg::st_t  st_nxt;
  sdp_pkg::out_t res;

  logic        out_can;
  logic        b_adv;
  logic [15:0] x_u;
  logic [15:0] y_u;
  logic [15:0] ax;
  logic [15:0] ay;

  assign out_can  = !out_valid_r || out_ready;
  assign b_adv    = !b_valid_r || out_can;
  assign in_ready = !a_valid_r || b_adv;

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Squaring stage: magnitudes are unsigned, so the most negative value
  // becomes 32768 without overflow.
  assign x_u = a_r.stick_x;
  assign y_u = a_r.stick_y;
  assign ax  = x_u[15] ? (~x_u + 16'd1) : x_u;
  assign ay  = y_u[15] ? (~y_u + 16'd1) : y_u;

  always_comb begin
    b_nxt.x_pos       = !x_u[15] && (x_u != 16'd0);
    b_nxt.y_pos       = !y_u[15] && (y_u != 16'd0);
    b_nxt.ax_gt_ay    = (ax > ay);
    b_nxt.ax_sq       = {16'd0, ax} * {16'd0, ax};
    b_nxt.ay_sq       = {16'd0, ay} * {16'd0, ay};
    b_nxt.eng_sq      = {16'd0, engage_r} * {16'd0, engage_r};
    b_nxt.rel_sq      = {16'd0, release_r} * {16'd0, release_r};
    b_nxt.button_bits = a_r.button_bits;
    b_nxt.menu_active = a_r.menu_active;
    b_nxt.now_ms      = a_r.now_ms;
    b_nxt.stick_x     = a_r.stick_x;
    b_nxt.stick_y     = a_r.stick_y;
  end

  sdp_decide u_decide (
    .smp        (b_r),
    .st_cur     (st_r),
    .press_time (press_r),
    .gap_time   (gap_r),
    .res        (res),
    .st_nxt     (st_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      engage_r  <= sdp_pkg::ENGAGE_RST;
      release_r <= sdp_pkg::RELEASE_RST;
      press_r   <= sdp_pkg::PRESS_RST;
      gap_r     <= sdp_pkg::GAP_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        sdp_pkg::CFG_ENGAGE:  engage_r  <= cfg_wdata;
        sdp_pkg::CFG_RELEASE: release_r <= cfg_wdata;
        sdp_pkg::CFG_PRESS:   press_r   <= cfg_wdata;
        sdp_pkg::CFG_GAP:     gap_r     <= cfg_wdata;
        default:              ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        a_valid_r <= in_valid;
      end
      if (b_adv) begin
        b_valid_r <= a_valid_r;
      end
      if (out_can) begin
        out_valid_r <= b_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      a_r <= in_data;
    end
    if (b_adv && a_valid_r) begin
      b_r <= b_nxt;
    end
    if (out_can && b_valid_r) begin
      out_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.held        <= sdp_pkg::DIR_NONE;
      st_r.pulse_high  <= 1'b1;
      st_r.phase_start <= '0;
    end else if (out_can && b_valid_r) begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== rtl/sdp_checker.sv =====
// ----------------------------------------------------------------------------
// sdp_checker: port-level checks for the stick to d-pad pulser
// Watches reset behavior, backpressure and result stability at the ports.
// ----------------------------------------------------------------------------
module sdp_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input sdp_pkg::out_t out_data
);

  // After reset the pipeline is empty and takes requests.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // The input side only stalls when a finished result is waiting.
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting result");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

endmodule

bind stick_to_dpad_pulser_unit sdp_checker u_sdp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== bench/stick_to_dpad_pulser_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stick_to_dpad_pulser_unit_tb: self-checking bench for the stick to d-pad pulser
// A scoreboard predicts every result from the accepted requests, with its own
// copy of the registers, the held direction and the pulse phase. Directed
// requests cover the corner cases; random stick gestures cover the rest.
// Both sides of the handshake stall at random.
// ----------------------------------------------------------------------------
module stick_to_dpad_pulser_unit_tb;

  localparam int LONG_HOLD = 300;
  localparam int PHASE_REQS = 100;

  // Predicts the translated gamepad sample and keeps the queue of expected results.
  class pulser_scoreboard;
    logic [15:0]   engage_lvl, release_lvl, press_len, gap_ms;
    sdp_pkg::dir_t held;
    bit            pulse_on;
    logic [31:0]   phase_t0;
    sdp_pkg::out_t expected_q[$];
    int            errors, checked, passthru_cnt, engaged_cnt, toggle_cnt, turn_cnt, letgo_cnt;

    function new();
      engage_lvl  = sdp_pkg::ENGAGE_RST;
      release_lvl = sdp_pkg::RELEASE_RST;
      press_len   = sdp_pkg::PRESS_RST;
      gap_ms      = sdp_pkg::GAP_RST;
      held        = sdp_pkg::DIR_NONE;
      pulse_on    = 1'b1;
      phase_t0    = '0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        sdp_pkg::CFG_ENGAGE:  engage_lvl = val;
        sdp_pkg::CFG_RELEASE: release_lvl = val;
        sdp_pkg::CFG_PRESS:   press_len = val;
        sdp_pkg::CFG_GAP:     gap_ms = val;
        default: ;
      endcase
    endfunction

    function void note_request(sdp_pkg::in_t req);
      logic [15:0]   ax, ay;
      logic [32:0]   mag, lim;
      logic [31:0]   elapsed;
      sdp_pkg::dir_t dir;
      sdp_pkg::out_t res;
      res.button_out  = req.button_bits;
      res.stick_x_out = req.stick_x;
      res.stick_y_out = req.stick_y;
      if (!req.menu_active) begin
        passthru_cnt++;
        expected_q.push_back(res);
        return;
      end
      ax  = req.stick_x[15] ? ~req.stick_x + 16'd1 : req.stick_x;
      ay  = req.stick_y[15] ? ~req.stick_y + 16'd1 : req.stick_y;
      mag = {17'd0, ax} * {17'd0, ax} + {17'd0, ay} * {17'd0, ay};
      if (held == sdp_pkg::DIR_NONE) begin
        lim = {17'd0, engage_lvl} * {17'd0, engage_lvl};
      end else begin
        lim = {17'd0, release_lvl} * {17'd0, release_lvl};
      end
      dir = sdp_pkg::DIR_NONE;
      if (mag >= lim) begin
        // The vertical axis wins a tie.
        if (ax > ay) begin
          if (!req.stick_x[15] && req.stick_x != 0) dir = sdp_pkg::DIR_RIGHT;
          else dir = sdp_pkg::DIR_LEFT;
        end else begin
          if (!req.stick_y[15] && req.stick_y != 0) dir = sdp_pkg::DIR_UP;
          else dir = sdp_pkg::DIR_DOWN;
        end
      end
      res.button_out  = req.button_bits & ~sdp_pkg::DPAD_MASK;
      res.stick_x_out = '0;
      res.stick_y_out = '0;
      if (dir == sdp_pkg::DIR_NONE) begin
        if (held != sdp_pkg::DIR_NONE) letgo_cnt++;
        held     = sdp_pkg::DIR_NONE;
        pulse_on = 1'b1;
        phase_t0 = '0;
      end else begin
        engaged_cnt++;
        if (dir != held) begin
          turn_cnt++;
          held     = dir;
          pulse_on = 1'b1;
          phase_t0 = req.now_ms;
        end
        // The elapsed time wraps with the timestamp.
        elapsed = req.now_ms - phase_t0;
        if (pulse_on) begin
          if (elapsed >= {16'd0, press_len}) begin
            pulse_on = 1'b0;
            phase_t0 = req.now_ms;
            toggle_cnt++;
          end
        end else if (elapsed >= {16'd0, gap_ms}) begin
          pulse_on = 1'b1;
          phase_t0 = req.now_ms;
          toggle_cnt++;
        end
        if (pulse_on) begin
          case (held)
            sdp_pkg::DIR_UP:    res.button_out[0] = 1'b1;
            sdp_pkg::DIR_DOWN:  res.button_out[1] = 1'b1;
            sdp_pkg::DIR_LEFT:  res.button_out[2] = 1'b1;
            sdp_pkg::DIR_RIGHT: res.button_out[3] = 1'b1;
            default: ;
          endcase
        end
      end
      expected_q.push_back(res);
    endfunction

    function void check_result(sdp_pkg::out_t got);
      sdp_pkg::out_t want;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result %h arrived with nothing expected", $time, got);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.button_out !== want.button_out) begin
        errors++;
        $display("%0t: button_out expected %h actual %h", $time, want.button_out,
                 got.button_out);
      end
      if (got.stick_x_out !== want.stick_x_out) begin
        errors++;
        $display("%0t: stick_x_out expected %h actual %h", $time, want.stick_x_out,
                 got.stick_x_out);
      end
      if (got.stick_y_out !== want.stick_y_out) begin
        errors++;
        $display("%0t: stick_y_out expected %h actual %h", $time, want.stick_y_out,
                 got.stick_y_out);
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  sdp_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_ready;
  sdp_pkg::out_t out_data;
  logic          cfg_we;
  logic [1:0]    cfg_idx;
  logic [15:0]   cfg_wdata;

  pulser_scoreboard sb = new();
  int          sent;
  bit          offering;
  bit          steady;
  bit          hold_req;
  logic [31:0] clock_ms;

  stick_to_dpad_pulser_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 7) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic int clamp_axis(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int jit(int amp);
    return int'($urandom_range(0, 2 * amp)) - amp;
  endfunction

  function automatic int rand_axis();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic sdp_pkg::in_t mk(int x, int y, logic [15:0] b, bit m, logic [31:0] t);
    sdp_pkg::in_t r;
    r.stick_x     = 16'(x);
    r.stick_y     = 16'(y);
    r.button_bits = b;
    r.menu_active = m;
    r.now_ms      = t;
    return r;
  endfunction

  task automatic send(sdp_pkg::in_t req);
    in_data  <= req;
    in_valid <= 1'b1;
    offering = 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(req);
    sent++;
    if (!steady && $urandom_range(0, 2) == 0) begin
      in_valid <= 1'b0;
      offering = 1'b0;
      repeat (pick_gap()) @(posedge clk);
    end
  endtask

  // Stops offering and waits until every expected result has come back.
  task automatic drain();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic program_regs(logic [15:0] eng, logic [15:0] rel, logic [15:0] prs,
                              logic [15:0] gp);
    drain();
    write_reg(sdp_pkg::CFG_ENGAGE, eng);
    write_reg(sdp_pkg::CFG_RELEASE, rel);
    write_reg(sdp_pkg::CFG_PRESS, prs);
    write_reg(sdp_pkg::CFG_GAP, gp);
    cfg_we <= 1'b0;
  endtask

  // A stick held roughly in one place for a while, with the clock moving on.
  task automatic gesture();
    int len, r, x0, y0, amp, span, sel, tmp;
    len = $urandom_range(4, 30);
    sel = $urandom_range(0, 3);
    if (sel == 0) begin
      r = $urandom_range(15000, 32767);
    end else if (sel == 1) begin
      tmp = $urandom_range(0, 1) ? int'(sb.engage_lvl) : int'(sb.release_lvl);
      r   = clamp_axis(tmp + jit(1500));
      if (r < 0) r = 0;
    end else begin
      r = $urandom_range(0, 32767);
    end
    sel = $urandom_range(0, 3);
    case (sel)
      0: begin x0 = r; y0 = 0; end
      1: begin x0 = 0; y0 = r; end
      2: begin x0 = r; y0 = r; end
      default: begin
        x0 = r;
        y0 = $urandom_range(0, r);
        if ($urandom_range(0, 1)) begin
          tmp = x0; x0 = y0; y0 = tmp;
        end
      end
    endcase
    if ($urandom_range(0, 1)) x0 = -x0;
    if ($urandom_range(0, 1)) y0 = -y0;
    amp  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 2500);
    span = (int'(sb.press_len) + int'(sb.gap_ms)) / 2 + 3;
    repeat (len) begin
      clock_ms += $urandom_range(0, span);
      send(mk(clamp_axis(x0 + jit(amp)), clamp_axis(y0 + jit(amp)), 16'($urandom),
              $urandom_range(0, 15) != 0, clock_ms));
    end
    if ($urandom_range(0, 2) == 0) begin
      clock_ms += $urandom_range(0, span);
      send(mk(jit(300), jit(300), 16'($urandom), 1'b1, clock_ms));
    end
  endtask

  task automatic directed();
    send(mk(-32768, 32767, 16'hFFFF, 1'b0, 32'hFFFF_FFFF));
    send(mk(32767, 0, 16'hFFFF, 1'b1, 32'd1000));
    send(mk(32767, 0, 16'h0000, 1'b1, 32'd1109));
    send(mk(30000, 500, 16'h0000, 1'b1, 32'd1110));
    send(mk(9000, 0, 16'h0000, 1'b1, 32'd1159));
    send(mk(9000, 0, 16'h0000, 1'b1, 32'd1160));
    // Pass-through while a direction is held must leave the pulse alone.
    send(mk(0, 0, 16'hFFFF, 1'b0, 32'd5));
    send(mk(20000, -20000, 16'h0000, 1'b1, 32'd1200));
    send(mk(-20000, 20000, 16'h0000, 1'b1, 32'd1201));
    send(mk(-32768, 0, 16'h0000, 1'b1, 32'd1202));
    send(mk(0, -32768, 16'h0000, 1'b1, 32'd1203));
    send(mk(100, 100, 16'hFFFF, 1'b1, 32'd1204));
    send(mk(9000, 0, 16'h0000, 1'b1, 32'd1205));
    send(mk(0, 12000, 16'h0000, 1'b1, 32'hFFFF_FFF0));
    send(mk(0, 12000, 16'h0000, 1'b1, 32'h0000_005E));
    send(mk(0, -32768, 16'h5555, 1'b1, 32'hAAAA_AAAA));
    // With zero thresholds a centered stick reads as down, and a zero press
    // time turns the bit off on the very sample that engages.
    program_regs(16'd0, 16'd0, 16'd0, 16'd0);
    send(mk(0, 0, 16'h0000, 1'b1, 32'd7));
    send(mk(0, 0, 16'h0000, 1'b1, 32'd7));
    send(mk(0, 0, 16'hFFFF, 1'b1, 32'd8));
    program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send(mk(-32768, -32768, 16'h0000, 1'b1, 32'd0));
    send(mk(32767, 32767, 16'hFFFF, 1'b1, 32'hFFFF_FFFF));
  endtask

  // Result side: random stalls, an occasional long hold-off on request.
  initial begin
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!steady && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  initial begin
    int stop_at;
    logic [15:0] eng, rel, prs, gp;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_idx   <= sdp_pkg::CFG_ENGAGE;
    cfg_wdata <= '0;
    sent      = 0;
    offering  = 1'b0;
    steady    = 1'b0;
    hold_req  = 1'b0;
    clock_ms  = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: program_regs(sdp_pkg::ENGAGE_RST, sdp_pkg::RELEASE_RST, sdp_pkg::PRESS_RST,
                        sdp_pkg::GAP_RST);
        1: program_regs(16'd0, 16'd0, 16'd0, 16'd0);
        2: begin
          // A release level of zero keeps a direction held across long pulses.
          program_regs(16'd16000, 16'd0, 16'hFFFF, 16'hFFFF);
          clock_ms = 32'hFFFF_0000;
        end
        default: begin
          eng = $urandom_range(0, 1) ? 16'($urandom_range(2000, 30000))
                                     : 16'($urandom_range(0, 65535));
          rel = 16'($urandom_range(0, int'(eng) + 2000 > 65535 ? 65535 : int'(eng) + 2000));
          prs = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(0, 300));
          gp  = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                            : 16'($urandom_range(0, 300));
          program_regs(eng, rel, prs, gp);
          clock_ms = $urandom;
        end
      endcase
      steady = (ph == 0);
      if (ph == 1) hold_req = 1'b1;
      stop_at = sent + PHASE_REQS;
      while (sent < stop_at) begin
        if ($urandom_range(0, 9) == 0) begin
          send(mk(rand_axis(), rand_axis(), 16'($urandom), 1'($urandom_range(0, 1)),
                  $urandom));
        end else begin
          gesture();
        end
      end
    end

    drain();
    $display("Sent %0d requests (%0d passed through, %0d engaged), checked %0d results.",
             sent, sb.passthru_cnt, sb.engaged_cnt, sb.checked);
    $display("Saw %0d direction changes, %0d pulse toggles and %0d releases.",
             sb.turn_cnt, sb.toggle_cnt, sb.letgo_cnt);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("stick_to_dpad_pulser_unit_tb OK");
    end else begin
      $display("stick_to_dpad_pulser_unit_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d results outstanding.", sb.expected_q.size());
    $display("stick_to_dpad_pulser_unit_tb NOT OK");
    $finish;
  end

endmodule

// ===== stick_to_dpad_pulser_unit.f =====
rtl/sdp_pkg.sv
rtl/sdp_decide.sv
rtl/stick_to_dpad_pulser_unit.sv
rtl/sdp_checker.sv
bench/stick_to_dpad_pulser_unit_tb.sv
